// ===== rtl/orcm_pkg.sv =====
// Shared types and constants of the offset-calibrated RMS current meter.
package orcm_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int DC_W        = 16;
  localparam int WS_W        = 13;
  localparam int GAIN_W      = 16;
  localparam int ADDR_W      = 3;
  localparam int PDATA_W     = 32;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 40;

  localparam int DEF_MAX_WINDOW  = 4096;
  localparam int DEF_CAL_SAMPLES = 50;

  localparam logic [WS_W-1:0]        WINDOW_RESET = WS_W'(256);
  localparam logic [GAIN_W-1:0]      GAIN_RESET   = GAIN_W'(256);
  localparam logic [SAMPLE_BITS-1:0] OFFSET_RESET = SAMPLE_BITS'(512);

  // Register indexes, taken from paddr[2].
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_GAIN   = 1'b1;

  typedef enum logic [1:0] {
    KIND_MEASURE = 2'd0,
    KIND_CAL     = 2'd1,
    KIND_LOAD    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [SAMPLE_BITS-1:0] sample;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SQR,
    ST_DIV,
    ST_ROOT,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/orcm_front.sv =====
// Input side: accepts words, classifies the command and queues them two deep.
module orcm_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,  // [9:0] sample, rest unused
  input  logic [1:0]            s_tuser,  // [1:0] cmd
  output logic                  q_valid,
  output orcm_pkg::item_t       q_item,
  input  logic                  q_pop
);
  import orcm_pkg::*;

  item_t       entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  item_t       incoming;

  always_comb begin
    incoming.sample = s_tdata[SAMPLE_BITS-1:0];
    unique case (s_tuser)
      2'd0:    incoming.kind = KIND_MEASURE;
      2'd1:    incoming.kind = KIND_CAL;
      2'd2:    incoming.kind = KIND_LOAD;
      default: incoming.kind = KIND_NONE;
    endcase
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      priority if (push && !(q_pop && q_valid)) begin
        count <= count + 2'd1;
      end else if (!push && q_pop && q_valid) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= incoming;
    end
  end

endmodule

// ===== rtl/orcm_div.sv =====
// Restoring divider that produces one quotient bit a cycle.
module orcm_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);
  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] divisor;
  logic [DEN_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem, quot[NUM_W-1]};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot    <= num;
      rem     <= '0;
      divisor <= den;
    end else if (busy) begin
      // The remainder stays below the divisor, so its top bit drops out.
      rem  <= ge ? DEN_W'(trial - {1'b0, divisor}) : trial[DEN_W-1:0];
      quot <= {quot[NUM_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/orcm_back.sv =====
// Processing side: current, window sums, calibration, mean and root, result register.
module orcm_back #(
  parameter int MAX_WINDOW  = orcm_pkg::DEF_MAX_WINDOW,
  parameter int CAL_SAMPLES = orcm_pkg::DEF_CAL_SAMPLES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  orcm_pkg::item_t               q_item,
  output logic                          q_pop,
  input  logic [orcm_pkg::WS_W-1:0]     window_samples,
  input  logic [orcm_pkg::GAIN_W-1:0]   dc_gain,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [orcm_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [1:0]                    m_tuser
);
  import orcm_pkg::*;

  localparam int SB      = SAMPLE_BITS;
  localparam int WIN_CAP = (MAX_WINDOW < 8191) ? MAX_WINDOW : 8191;
  localparam int CNT_W   = $clog2(WIN_CAP + 1);
  localparam int CCNT_W  = $clog2(CAL_SAMPLES + 1);
  localparam int CSUM_W  = SB + CCNT_W;
  localparam int SQ_W    = 2 * SB + CNT_W;
  localparam int NUM_W   = SQ_W;
  localparam int DEN_W   = (CNT_W > CCNT_W) ? CNT_W : CCNT_W;
  localparam int PW      = SB + 18;
  localparam int RT_W    = 2 * SB;
  localparam logic [WS_W-1:0]          WS_CAP  = WS_W'(WIN_CAP);
  localparam logic signed [PW-1:0]     DC_HI   = PW'(32767);
  localparam logic signed [PW-1:0]     DC_LO   = PW'(-32768);
  localparam logic [CCNT_W-1:0]        CAL_N   = CCNT_W'(CAL_SAMPLES);

  state_t state, state_next;

  // Held state across items
  logic [SB-1:0]     offset;
  logic [SQ_W-1:0]   sq_sum;
  logic [CNT_W-1:0]  win_cnt;
  logic [CSUM_W-1:0] cal_sum;
  logic [CCNT_W-1:0] cal_cnt;

  // Per-item working registers
  kind_t                  kind;
  logic [SB-1:0]          smp;
  logic signed [SB:0]     diff;
  logic signed [PW-1:0]   prod;
  logic [DC_W-1:0]        dc;
  logic                   rms_valid;
  logic [SB-1:0]          rms_val;
  logic                   upd;
  logic [RT_W-1:0]        rt_val;
  logic [RT_W-1:0]        rt_res;
  logic [RT_W-1:0]        rt_bit;

  logic [CNT_W-1:0]       eff_win;
  logic [CNT_W-1:0]       cnt_n;
  logic                   win_end;
  logic signed [2*SB+1:0] sq;
  logic [SQ_W-1:0]        sq_sum_n;
  logic [CSUM_W-1:0]      cal_sum_n;
  logic [CCNT_W-1:0]      cal_cnt_n;
  logic                   cal_last;
  logic signed [PW-1:0]   rnd;
  logic signed [PW-1:0]   shd;
  logic [DC_W-1:0]        dc_sat;
  logic [RT_W-1:0]        rt_trial;
  logic                   rt_ge;
  logic [RT_W-1:0]        rt_res_n;
  logic                   out_free;

  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quot;

  orcm_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  always_comb begin
    priority if (window_samples == '0) begin
      eff_win = CNT_W'(1);
    end else if (window_samples > WS_CAP) begin
      eff_win = CNT_W'(WIN_CAP);
    end else begin
      eff_win = window_samples[CNT_W-1:0];
    end
  end

  assign cnt_n     = win_cnt + 1'b1;
  assign win_end   = (cnt_n >= eff_win);
  assign sq        = diff * diff;
  assign sq_sum_n  = sq_sum + SQ_W'(sq[2*SB-1:0]);
  assign cal_sum_n = cal_sum + CSUM_W'(smp);
  assign cal_cnt_n = cal_cnt + 1'b1;
  assign cal_last  = (cal_cnt_n >= CAL_N);

  // Round to nearest with ties upward, then clamp to the 16-bit range.
  assign rnd = prod + PW'(128);
  assign shd = rnd >>> 8;
  always_comb begin
    priority if (shd > DC_HI) begin
      dc_sat = DC_W'(32767);
    end else if (shd < DC_LO) begin
      dc_sat = DC_W'(-32768);
    end else begin
      dc_sat = shd[DC_W-1:0];
    end
  end

  assign rt_trial = rt_res + rt_bit;
  assign rt_ge    = (rt_val >= rt_trial);
  assign rt_res_n = rt_ge ? (rt_res >> 1) + rt_bit : rt_res >> 1;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = ST_PROD;
        end
      end
      ST_PROD: begin
        unique case (kind)
          KIND_MEASURE: state_next = ST_SQR;
          KIND_CAL: begin
            if (cal_last) begin
              div_start  = 1'b1;
              div_num    = NUM_W'(cal_sum_n);
              div_den    = DEN_W'(cal_cnt_n);
              state_next = ST_DIV;
            end else begin
              state_next = ST_OUT;
            end
          end
          default: state_next = ST_OUT;
        endcase
      end
      ST_SQR: begin
        if (win_end) begin
          div_start  = 1'b1;
          div_num    = sq_sum_n;
          div_den    = DEN_W'(cnt_n);
          state_next = ST_DIV;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = (kind == KIND_CAL) ? ST_OUT : ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rt_bit[0]) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset   <= OFFSET_RESET;
      sq_sum   <= '0;
      win_cnt  <= '0;
      cal_sum  <= '0;
      cal_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // In the output step a taken word is replaced by the new one below.
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_PROD: begin
          if (kind == KIND_CAL) begin
            cal_sum <= cal_last ? '0 : cal_sum_n;
            cal_cnt <= cal_last ? '0 : cal_cnt_n;
          end else if (kind == KIND_LOAD) begin
            offset  <= smp;
            cal_sum <= '0;
            cal_cnt <= '0;
          end
        end
        ST_SQR: begin
          sq_sum  <= win_end ? '0 : sq_sum_n;
          win_cnt <= win_end ? '0 : cnt_n;
        end
        ST_DIV: begin
          if (div_done && kind == KIND_CAL) begin
            offset <= div_quot[SB-1:0];
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          kind      <= q_item.kind;
          smp       <= q_item.sample;
          diff      <= $signed({1'b0, offset}) - $signed({1'b0, q_item.sample});
          dc        <= '0;
          rms_valid <= 1'b0;
          rms_val   <= '0;
          upd       <= 1'b0;
        end
      end
      ST_PROD: begin
        prod <= diff * $signed({1'b0, dc_gain});
        if (kind == KIND_LOAD) begin
          upd <= 1'b1;
        end
      end
      ST_SQR: begin
        dc <= dc_sat;
      end
      ST_DIV: begin
        if (div_done) begin
          if (kind == KIND_CAL) begin
            upd <= 1'b1;
          end else begin
            // The mean never exceeds the largest squared deviation.
            rt_val <= div_quot[RT_W-1:0];
            rt_res <= '0;
            rt_bit <= RT_W'(1) << (RT_W - 2);
          end
        end
      end
      ST_ROOT: begin
        if (rt_ge) begin
          rt_val <= rt_val - rt_trial;
        end
        rt_res <= rt_res_n;
        rt_bit <= rt_bit >> 2;
        if (rt_bit[0]) begin
          rms_val   <= rt_res_n[SB-1:0];
          rms_valid <= 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          m_tdata <= {4'b0, offset, rms_val, dc};
          m_tuser <= {upd, rms_valid};
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/offset_rms_current_meter.sv =====
// Top level of the offset-calibrated RMS current meter with its register port.
//
//   Channel  Direction  Handshake                Payload
//   s_*      in         s_tvalid / s_tready      tdata: sample; tuser: cmd
//   m_*      out        m_tvalid / m_tready      tdata: dc_current, rms_value, offset_now;
//                                                tuser: rms_valid, offset_updated
//   APB      in         psel, penable, pready    0x0 window_samples, 0x4 dc_gain
//
// Each word is handled alone: load, unused commands and calibration samples
// pass the idle, product and output steps, and a measure sample adds the
// square step before output. The sample that closes a window then also runs
// the bit-serial divider and the two-bit-a-step root. A closing calibration
// sample runs the divider pass after the product step instead of the square
// step and the root. Reset empties the two-word input queue, sets the
// offset to mid-scale and clears the sums. When the result register is full,
// the sequencer holds in its last step and the queue takes words while it has room.
module offset_rms_current_meter #(
  parameter int MAX_WINDOW  = orcm_pkg::DEF_MAX_WINDOW,
  parameter int CAL_SAMPLES = orcm_pkg::DEF_CAL_SAMPLES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [orcm_pkg::S_TDATA_W-1:0]  s_tdata,  // [9:0] sample, [15:10] zero
  input  logic [1:0]                      s_tuser,  // [1:0] cmd
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [orcm_pkg::M_TDATA_W-1:0]  m_tdata,  // [15:0] dc_current, [25:16] rms_value,
                                                    // [35:26] offset_now, [39:36] zero
  output logic [1:0]                      m_tuser,  // [0] rms_valid, [1] offset_updated
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [orcm_pkg::ADDR_W-1:0]     paddr,
  input  logic [orcm_pkg::PDATA_W-1:0]    pwdata,
  output logic [orcm_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import orcm_pkg::*;

  logic [WS_W-1:0]   window_samples;
  logic [GAIN_W-1:0] dc_gain;
  logic              reg_index;
  logic              q_valid;
  item_t             q_item;
  logic              q_pop;

  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_samples <= WINDOW_RESET;
      dc_gain        <= GAIN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_index)
        REG_WINDOW: window_samples <= pwdata[WS_W-1:0];
        REG_GAIN:   dc_gain        <= pwdata[GAIN_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_WINDOW: prdata = PDATA_W'(window_samples);
      REG_GAIN:   prdata = PDATA_W'(dc_gain);
      default:    prdata = '0;
    endcase
  end

  orcm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop)
  );

  orcm_back #(
    .MAX_WINDOW (MAX_WINDOW),
    .CAL_SAMPLES(CAL_SAMPLES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .window_samples(window_samples),
    .dc_gain       (dc_gain),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser)
  );

endmodule
